/* rtl/tlpd_pkg.sv */
// ----------------------------------------------------------------------------
// Tagged length-prefix deframer package
// Shared sizes, codes and the policy request text of the deframer.
// ----------------------------------------------------------------------------
package tlpd_pkg;

  localparam int HEADER_BYTES  = 8;
  localparam int POLICY_LENGTH = 22;

  localparam int HIDX_W  = $clog2(HEADER_BYTES);
  localparam int BURST_W = $clog2(HEADER_BYTES + 1);
  localparam int PIDX_W  = $clog2(POLICY_LENGTH + 1);
  localparam int LEN_W   = 24;
  localparam int TAG_W   = 32;

  localparam logic [8*POLICY_LENGTH-1:0] POLICY_TEXT = "<policy-file-request/>";

  localparam logic [LEN_W-1:0] LIMIT_RESET = 24'd65536;

  localparam logic REG_TAG   = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_POLICY  = 2'd1,
    KIND_BAD_TAG = 2'd2,
    KIND_BAD_LEN = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_BODY   = 4'b0010,
    PH_ERROR  = 4'b0100,
    PH_HELD   = 4'b1000
  } phase_t;

  function automatic logic [7:0] policy_char(input logic [PIDX_W-1:0] idx);
    logic [7:0] c;
    c = 8'd0;
    for (int i = 0; i < POLICY_LENGTH; i++) begin
      if (idx == PIDX_W'(i)) begin
        c = POLICY_TEXT[8*(POLICY_LENGTH-1-i) +: 8];
      end
    end
    return c;
  endfunction

endpackage

/* rtl/tlpd_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module tlpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/tagged_length_prefix_deframer_unit.sv */
// ----------------------------------------------------------------------------
// Tagged length-prefix deframer
// Splits a connection byte stream into tagged, length-prefixed messages.
// ----------------------------------------------------------------------------
// Usage:
// The in_ channel carries one stream byte per transfer; in_tuser marks the
// first byte of a new connection. The out_ channel carries message bytes
// and events, with in-band kind and message boundary flags in out_tuser and
// out_tlast closing the results caused by one input byte.
// Header bytes are gathered in a small RAM and produce no output until the
// header is complete. A good header is then replayed from the RAM, one byte
// per cycle while the receiver takes them, so it leaves in 8 transfers; the
// input is held off until the replay has been read out. Body bytes leave in
// the cycle after they are accepted, one byte per cycle while the receiver
// does not stall. A policy request at the start of a connection gives a
// single event transfer; a bad tag or length gives one error transfer, after
// which bytes are dropped until the next connection starts.
// Reset clears the stream control state, arms the policy check and loads the
// register defaults. When the receiver stalls, the output register holds its
// transfer; input is accepted only while it can be refilled. The cfg_ channel
// is always ready; the user must write it only while the block idles (not enforced).
// ----------------------------------------------------------------------------
module tagged_length_prefix_deframer_unit
  import tlpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic [3:0]  out_tuser,  // [1:0] kind, [2] first_of_message, [3] last_of_message
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic [TAG_W-1:0]   cfg_tag_r;
  logic [LEN_W-1:0]   cfg_limit_r;

  phase_t             phase_r, phase_nxt, phase_e;
  logic [LEN_W-1:0]   bim_r, bim_nxt, bim_e, bim_inc;
  logic [LEN_W-1:0]   msg_len_r, msg_len_nxt;
  logic [PIDX_W-1:0]  pidx_r, pidx_nxt, pidx_e;
  logic               armed_r, armed_nxt, armed_e;
  logic               pend_r, pend_nxt, pend_e;
  logic [TAG_W-1:0]   tag_r, tag_nxt;
  logic [31:0]        hlen_r, hlen_nxt;

  logic [BURST_W-1:0] burst_left_r, burst_left_nxt;
  logic [HIDX_W-1:0]  rd_addr_r, rd_addr_nxt;
  logic [HIDX_W-1:0]  rd_pos_r, rd_pos_nxt;
  logic               rdv_r, rdv_nxt;
  logic               len8_r, len8_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_byte_r, out_byte_nxt;
  kind_t              out_kind_r, out_kind_nxt;
  logic               out_first_r, out_first_nxt;
  logic               out_lastm_r, out_lastm_nxt;
  logic               out_last_r, out_last_nxt;

  logic               out_free, busy, in_fire, move, issue;
  logic               res_valid, res_lastm, hdr_done, store;
  kind_t              res_kind;
  logic [7:0]         rd_data;

  assign out_free  = !out_valid_r || out_tready;
  assign busy      = (burst_left_r != '0) || rdv_r;
  assign in_tready = !busy && out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign move      = rdv_r && out_free;
  assign issue     = (burst_left_r != '0) && (!rdv_r || move);
  assign cfg_ready = 1'b1;

  assign bim_e    = in_tuser ? '0 : bim_r;
  assign phase_e  = in_tuser ? PH_HEADER : phase_r;
  assign pidx_e   = in_tuser ? '0 : pidx_r;
  assign armed_e  = in_tuser ? 1'b1 : armed_r;
  assign pend_e   = in_tuser ? 1'b0 : pend_r;
  assign bim_inc  = bim_e + LEN_W'(1);
  assign hdr_done = (bim_e == LEN_W'(HEADER_BYTES - 1));

  always_comb begin
    tag_nxt  = tag_r;
    hlen_nxt = hlen_r;
    if (in_fire && (phase_e == PH_HEADER)) begin
      if (bim_e < LEN_W'(4)) begin
        tag_nxt[8*bim_e[1:0] +: 8] = in_tdata;
      end else if (bim_e < LEN_W'(8)) begin
        hlen_nxt[8*bim_e[1:0] +: 8] = in_tdata;
      end
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    bim_nxt        = bim_r;
    msg_len_nxt    = msg_len_r;
    pidx_nxt       = pidx_r;
    armed_nxt      = armed_r;
    pend_nxt       = pend_r;
    burst_left_nxt = burst_left_r;
    rd_addr_nxt    = rd_addr_r;
    len8_nxt       = len8_r;
    res_valid      = 1'b0;
    res_kind       = KIND_BYTE;
    res_lastm      = 1'b0;
    store          = 1'b0;

    if (in_fire) begin
      phase_nxt = phase_e;
      bim_nxt   = bim_e;
      pidx_nxt  = pidx_e;
      armed_nxt = armed_e;
      pend_nxt  = pend_e;
      if (in_tuser) begin
        msg_len_nxt = '0;
      end

      if (armed_e && (pidx_e < PIDX_W'(POLICY_LENGTH)) &&
          (in_tdata == policy_char(pidx_e))) begin
        if (pidx_e == PIDX_W'(POLICY_LENGTH - 1)) begin
          phase_nxt   = PH_HEADER;
          bim_nxt     = '0;
          msg_len_nxt = '0;
          pend_nxt    = 1'b0;
          armed_nxt   = 1'b0;
          pidx_nxt    = '0;
          res_valid   = 1'b1;
          res_kind    = KIND_POLICY;
        end else begin
          pidx_nxt = pidx_e + PIDX_W'(1);
          if (phase_e == PH_HEADER) begin
            store   = 1'b1;
            bim_nxt = bim_inc;
            if (hdr_done) begin
              pend_nxt  = (tag_nxt != cfg_tag_r);
              phase_nxt = PH_HELD;
            end
          end
        end
      end else begin
        armed_nxt = 1'b0;
        pidx_nxt  = '0;
        if (armed_e && (phase_e == PH_HELD)) begin
          res_valid = 1'b1;
          res_kind  = pend_e ? KIND_BAD_TAG : KIND_BAD_LEN;
          phase_nxt = PH_ERROR;
        end else begin
          unique case (phase_e) inside
            PH_HEADER: begin
              store   = 1'b1;
              bim_nxt = bim_inc;
              if (hdr_done) begin
                if (tag_nxt != cfg_tag_r) begin
                  res_valid = 1'b1;
                  res_kind  = KIND_BAD_TAG;
                  phase_nxt = PH_ERROR;
                end else if ((hlen_nxt < 32'(HEADER_BYTES)) ||
                             (hlen_nxt >= {8'd0, cfg_limit_r})) begin
                  res_valid = 1'b1;
                  res_kind  = KIND_BAD_LEN;
                  phase_nxt = PH_ERROR;
                end else begin
                  msg_len_nxt    = hlen_nxt[LEN_W-1:0];
                  burst_left_nxt = BURST_W'(HEADER_BYTES);
                  rd_addr_nxt    = '0;
                  len8_nxt       = (hlen_nxt == 32'(HEADER_BYTES));
                  if (hlen_nxt == 32'(HEADER_BYTES)) begin
                    bim_nxt   = '0;
                    phase_nxt = PH_HEADER;
                  end else begin
                    bim_nxt   = LEN_W'(HEADER_BYTES);
                    phase_nxt = PH_BODY;
                  end
                end
              end
            end
            PH_BODY: begin
              res_valid = 1'b1;
              res_kind  = KIND_BYTE;
              res_lastm = (bim_inc >= msg_len_r);
              bim_nxt   = bim_inc;
              if (bim_inc >= msg_len_r) begin
                bim_nxt   = '0;
                phase_nxt = PH_HEADER;
              end
            end
            PH_ERROR, PH_HELD: begin
            end
            default: begin
            end
          endcase
        end
      end
    end

    if (issue) begin
      burst_left_nxt = burst_left_r - BURST_W'(1);
      rd_addr_nxt    = rd_addr_r + HIDX_W'(1);
    end
  end

  always_comb begin
    rdv_nxt    = rdv_r;
    rd_pos_nxt = rd_pos_r;
    if (issue) begin
      rdv_nxt    = 1'b1;
      rd_pos_nxt = rd_addr_r;
    end else if (move) begin
      rdv_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_kind_nxt  = out_kind_r;
    out_first_nxt = out_first_r;
    out_lastm_nxt = out_lastm_r;
    out_last_nxt  = out_last_r;
    if (move) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = rd_data;
      out_kind_nxt  = KIND_BYTE;
      out_first_nxt = (rd_pos_r == '0);
      out_lastm_nxt = (rd_pos_r == HIDX_W'(HEADER_BYTES - 1)) && len8_r;
      out_last_nxt  = (rd_pos_r == HIDX_W'(HEADER_BYTES - 1));
    end else if (in_fire && res_valid) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = (res_kind == KIND_BYTE) ? in_tdata : 8'd0;
      out_kind_nxt  = res_kind;
      out_first_nxt = 1'b0;
      out_lastm_nxt = res_lastm;
      out_last_nxt  = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  tlpd_ram #(
    .WIDTH(8),
    .DEPTH(HEADER_BYTES)
  ) u_hdr_ram (
    .clk    (clk),
    .wr_en  (in_fire && store),
    .wr_addr(bim_e[HIDX_W-1:0]),
    .wr_data(in_tdata),
    .rd_en  (issue),
    .rd_addr(rd_addr_r),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_tag_r    <= '0;
      cfg_limit_r  <= LIMIT_RESET;
      phase_r      <= PH_HEADER;
      bim_r        <= '0;
      msg_len_r    <= '0;
      pidx_r       <= '0;
      armed_r      <= 1'b1;
      pend_r       <= 1'b0;
      burst_left_r <= '0;
      rd_addr_r    <= '0;
      rdv_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_TAG:   cfg_tag_r   <= cfg_data;
          REG_LIMIT: cfg_limit_r <= cfg_data[LEN_W-1:0];
          default:   cfg_tag_r   <= cfg_tag_r;
        endcase
      end
      phase_r      <= phase_nxt;
      bim_r        <= bim_nxt;
      msg_len_r    <= msg_len_nxt;
      pidx_r       <= pidx_nxt;
      armed_r      <= armed_nxt;
      pend_r       <= pend_nxt;
      burst_left_r <= burst_left_nxt;
      rd_addr_r    <= rd_addr_nxt;
      rdv_r        <= rdv_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r       <= tag_nxt;
    hlen_r      <= hlen_nxt;
    rd_pos_r    <= rd_pos_nxt;
    len8_r      <= len8_nxt;
    out_byte_r  <= out_byte_nxt;
    out_kind_r  <= out_kind_nxt;
    out_first_r <= out_first_nxt;
    out_lastm_r <= out_lastm_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = {out_lastm_r, out_first_r, out_kind_r};
  assign out_tlast  = out_last_r;

  a_held_armed: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HELD |-> armed_r)
    else $error("held header while the policy check is disarmed");

  a_error_disarmed: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ERROR |-> !armed_r)
    else $error("error state while the policy check is armed");

  a_body_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> bim_r < msg_len_r)
    else $error("body byte count reached the message length");

  a_burst_start: assert property (@(posedge clk) disable iff (!rst_n)
    burst_left_r == BURST_W'(HEADER_BYTES) |-> $past(in_fire))
    else $error("header replay started without an input transfer");

  a_ram_ports: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> !(in_fire && store))
    else $error("header RAM written during replay");

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Tagged length-prefix deframer testbench
// Drives connection byte streams of well-formed messages, bad headers, policy
// request text and noise through the deframer, under random idle cycles and
// receiver stalls. A scoreboard predicts every output transfer from the
// accepted input bytes and the register settings, and compares each one.
// ----------------------------------------------------------------------------
module testbench
  import tlpd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       first;
    logic       lastm;
    logic       lst;
  } transfer_t;

  class frame_tracker;
    logic [31:0] tag_reg;
    logic [23:0] limit_reg;
    logic [7:0]  hdr[HEADER_BYTES];
    logic [23:0] count;
    logic [23:0] msg_len;
    phase_t      ph;
    int          pol_pos;
    bit          armed;
    bit          held_bad_tag;
    transfer_t   due[$];
    int          fails;

    function new();
      tag_reg   = '0;
      limit_reg = LIMIT_RESET;
      foreach (hdr[i]) hdr[i] = 8'd0;
      restart_stream();
      pol_pos = 0;
      armed   = 1'b1;
      fails   = 0;
    endfunction

    static function logic [7:0] text_char(int i);
      return POLICY_TEXT[8*(POLICY_LENGTH-1-i) +: 8];
    endfunction

    function void set_reg(logic idx, logic [31:0] v);
      if (idx == REG_TAG) tag_reg = v;
      else limit_reg = v[23:0];
    endfunction

    function void restart_stream();
      count        = '0;
      msg_len      = '0;
      ph           = PH_HEADER;
      held_bad_tag = 1'b0;
    endfunction

    function void push(logic [7:0] d, kind_t k, logic f, logic lm);
      due.push_back('{d, k, f, lm, 1'b0});
    endfunction

    function void fail_header(bit bad_tag);
      push(8'd0, bad_tag ? KIND_BAD_TAG : KIND_BAD_LEN, 1'b0, 1'b0);
      ph = PH_ERROR;
    endfunction

    function void store_header_byte(logic [7:0] b);
      if (count < HEADER_BYTES) hdr[count] = b;
      count = count + 24'd1;
    endfunction

    function void release_header();
      logic [31:0] t;
      logic [31:0] l;
      t = {hdr[3], hdr[2], hdr[1], hdr[0]};
      l = {hdr[7], hdr[6], hdr[5], hdr[4]};
      if (t != tag_reg) begin
        fail_header(1'b1);
        return;
      end
      if (l < HEADER_BYTES || l >= {8'd0, limit_reg}) begin
        fail_header(1'b0);
        return;
      end
      msg_len = l[23:0];
      for (int i = 0; i < HEADER_BYTES; i++)
        push(hdr[i], KIND_BYTE, i == 0, (i == HEADER_BYTES - 1) && l == HEADER_BYTES);
      if (l == HEADER_BYTES) begin
        count = '0;
        ph    = PH_HEADER;
      end else begin
        count = HEADER_BYTES;
        ph    = PH_BODY;
      end
    endfunction

    function void plain_byte(logic [7:0] b);
      case (ph)
        PH_HEADER: begin
          store_header_byte(b);
          if (count >= HEADER_BYTES) release_header();
        end
        PH_BODY: begin
          count = count + 24'd1;
          push(b, KIND_BYTE, 1'b0, count >= msg_len);
          if (count >= msg_len) begin
            count = '0;
            ph    = PH_HEADER;
          end
        end
        default: ;
      endcase
    endfunction

    function void accept_byte(logic [7:0] b, logic r);
      int n0;
      n0 = due.size();
      if (r) begin
        restart_stream();
        pol_pos = 0;
        armed   = 1'b1;
      end
      if (armed && pol_pos < POLICY_LENGTH && b == text_char(pol_pos)) begin
        pol_pos++;
        if (pol_pos >= POLICY_LENGTH) begin
          restart_stream();
          armed   = 1'b0;
          pol_pos = 0;
          push(8'd0, KIND_POLICY, 1'b0, 1'b0);
        end else if (ph == PH_HEADER) begin
          store_header_byte(b);
          if (count >= HEADER_BYTES) begin
            held_bad_tag = {hdr[3], hdr[2], hdr[1], hdr[0]} != tag_reg;
            ph = PH_HELD;
          end
        end
      end else if (armed) begin
        armed   = 1'b0;
        pol_pos = 0;
        if (ph == PH_HELD) fail_header(held_bad_tag);
        else plain_byte(b);
      end else begin
        plain_byte(b);
      end
      if (due.size() > n0) due[due.size()-1].lst = 1'b1;
    endfunction

    function void compare_transfer(logic [7:0] d, logic [3:0] u, logic l);
      transfer_t e;
      if (due.size() == 0) begin
        $error("unexpected transfer: out_byte %0h out_tuser %0h", d, u);
        fails++;
        return;
      end
      e = due.pop_front();
      if (d !== e.data) begin
        $error("out_byte: expected %0h, got %0h", e.data, d);
        fails++;
      end
      if (u[1:0] !== e.kind) begin
        $error("kind: expected %0d, got %0d", e.kind, u[1:0]);
        fails++;
      end
      if (u[2] !== e.first) begin
        $error("first_of_message: expected %0b, got %0b", e.first, u[2]);
        fails++;
      end
      if (u[3] !== e.lastm) begin
        $error("last_of_message: expected %0b, got %0b", e.lastm, u[3]);
        fails++;
      end
      if (l !== e.lst) begin
        $error("last: expected %0b, got %0b", e.lst, l);
        fails++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  frame_tracker board;
  bit           stall_on;
  int           sent;
  int           cycles;

  tagged_length_prefix_deframer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.compare_transfer(out_tdata, out_tuser, out_tlast);
    out_tready <= stall_on ? ($urandom_range(99) >= 25) : 1'b1;
  end

  task automatic send_byte(logic [7:0] d, logic r);
    if (stall_on && $urandom_range(99) < 25) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= r;
    do @(posedge clk); while (!in_tready);
    board.accept_byte(d, r);
    sent++;
  endtask

  task automatic send_header(logic [31:0] tag, logic [31:0] len, logic r);
    for (int i = 0; i < 4; i++) send_byte(tag[8*i +: 8], r && i == 0);
    for (int i = 0; i < 4; i++) send_byte(len[8*i +: 8], 1'b0);
  endtask

  task automatic send_message(int len, logic r);
    send_header(board.tag_reg, len, r);
    repeat (len - HEADER_BYTES) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic send_policy(int n, logic r);
    for (int i = 0; i < n; i++) send_byte(frame_tracker::text_char(i), r && i == 0);
  endtask

  task automatic send_noise(int n, logic r);
    for (int i = 0; i < n; i++) send_byte(8'($urandom), (r && i == 0) || $urandom_range(7) == 0);
  endtask

  task automatic write_regs(logic [31:0] tag, logic [31:0] limit);
    cfg_valid <= 1'b1;
    cfg_index <= REG_TAG;
    cfg_data  <= tag;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(REG_TAG, tag);
    cfg_index <= REG_LIMIT;
    cfg_data  <= limit;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(REG_LIMIT, limit);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_traffic(int items);
    int          start_n;
    int          pick;
    int          hi;
    logic        rs;
    logic [31:0] len;
    start_n = sent;
    while (sent - start_n < items) begin
      pick = $urandom_range(99);
      rs   = board.ph != PH_HEADER || $urandom_range(3) == 0;
      if (pick < 55) begin
        hi = (board.limit_reg > 24'd29) ? 28 : int'(board.limit_reg) - 1;
        if (hi < HEADER_BYTES) hi = HEADER_BYTES;
        send_message($urandom_range(hi, HEADER_BYTES), rs);
      end else if (pick < 65) begin
        send_header(board.tag_reg ^ (32'd1 << $urandom_range(31)), $urandom_range(40, 8), rs);
        send_noise($urandom_range(2), 1'b0);
      end else if (pick < 75) begin
        case ($urandom_range(2))
          0: len = $urandom_range(7, 0);
          1: len = {8'd0, board.limit_reg} + $urandom_range(3, 0);
          default: len = {8'($urandom_range(255, 1)), 24'($urandom)};
        endcase
        send_header(board.tag_reg, len, rs);
      end else if (pick < 87) begin
        send_policy(($urandom_range(2) == 0) ? POLICY_LENGTH : $urandom_range(21, 1), 1'b1);
        send_noise($urandom_range(3, 1), 1'b0);
      end else begin
        send_noise($urandom_range(6, 1), $urandom_range(3) == 0);
      end
    end
  endtask

  initial begin
    board      = new();
    stall_on   = 1'b1;
    sent       = 0;
    cycles     = 0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'd0;
    in_tuser   = 1'b0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_TAG;
    cfg_data   = 32'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_policy(POLICY_LENGTH, 1'b1);
    send_message(HEADER_BYTES, 1'b0);
    send_message(10, 1'b0);
    send_header(32'h0000_0001, 32'd12, 1'b1);
    send_noise(1, 1'b0);
    send_header(32'd0, 32'd7, 1'b1);
    send_header(32'd0, {8'd0, LIMIT_RESET}, 1'b1);
    send_policy(9, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    random_traffic(12);
    drain();

    write_regs(32'h6c6f_703c, 32'd9);
    send_policy(8, 1'b1);
    send_byte(8'hff, 1'b0);
    send_message(HEADER_BYTES, 1'b1);
    random_traffic(10);
    drain();

    stall_on = 1'b0;
    write_regs(32'hffff_ffff, 32'hffff_ffff);
    random_traffic(12);
    drain();

    stall_on = 1'b1;
    write_regs($urandom, 32'd5);
    random_traffic(6);
    drain();

    write_regs($urandom, $urandom_range(300, 20));
    random_traffic(12);
    drain();

    if (board.fails == 0 && board.due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
